/* design/ctr_pkg.sv */
// Shared constants and elaboration-time table builders for the color
// temperature to RGB compare block. No dependencies.
package ctr_pkg;

    localparam int TABLE_BITS_DEF   = 8;
    localparam int X_W              = 18;       // log argument, unsigned
    localparam int L_W              = 24;       // signed Q16 log / exponent
    localparam int P_W              = 17;       // level / power, 0..65536
    localparam int ONE_Q16          = 65536;
    localparam int FULL_SCALE_RESET = 50000;

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned w;
        r = 64'd0;
        b = 64'd1 << 62;
        w = v;
        while (b > w) b = b >> 2;
        while (b != 64'd0) begin
            if (w >= r + b) begin
                w = w - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/2^tb) in Q16 by repeated squaring
    function automatic logic [P_W-1:0] log_entry(input int tb, input int i);
        longint unsigned y;
        logic [31:0] frac;
        if (i >= (1 << tb)) return P_W'(ONE_Q16);
        y = (64'd1 << 30) + (64'(i) << (30 - tb));
        frac = 32'd0;
        for (int n = 0; n < 20; n++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31)) begin
                frac = frac | 32'd1;
                y = y >> 1;
            end
        end
        return P_W'((frac + 32'd8) >> 4);
    endfunction

    // 2^(i/2^tb) in Q30 as a product of successive square roots of two
    function automatic logic [31:0] exp_entry(input int tb, input int i);
        longint unsigned acc;
        longint unsigned rt;
        if (i >= (1 << tb)) return 32'h8000_0000;
        acc = 64'd1 << 30;
        rt  = 64'd1 << 31;
        for (int j = 1; j <= tb; j++) begin
            rt = isqrt64(rt << 30);
            if (((i >> (tb - j)) & 1) != 0) acc = (acc * rt) >> 30;
        end
        return 32'(acc);
    endfunction

endpackage

/* design/color_temperature_to_rgb_pwm_top.sv */
// Top level: color temperature in kelvin to red, green and blue PWM compare values.
// Depends on ctr_pkg, ctr_log2 and ctr_exp2.
//
// One temperature is taken per clock while o_stall is low. The pipeline stages
// are divide by 100, channel mode select, curve log2, coefficient multiply,
// 2^x, level scale, gamma log2, gamma multiply, 2^x and full-scale multiply.
// Each stage has its own valid bit and advances whenever the stage after it
// is free, so bubbles close up while the output is stalled and the input
// keeps taking items until the pipeline is full.
// The log2 and 2^x tables are built at elaboration from TABLE_BITS. A write
// to full_scale takes effect on the next cycle and must be made while idle.
module color_temperature_to_rgb_pwm_top #(
    parameter int TABLE_BITS = ctr_pkg::TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_full_scale_we,
    input  logic [15:0] i_full_scale,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_kelvin,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_red_compare,
    output logic [15:0] o_green_compare,
    output logic [15:0] o_blue_compare
);

    localparam int XW     = ctr_pkg::X_W;
    localparam int LW     = ctr_pkg::L_W;
    localparam int PW     = ctr_pkg::P_W;
    localparam int NST    = 16;
    localparam int Q0_W   = 45;
    localparam int DIV_SH = 27;
    localparam logic [22:0] DIV_M = 23'd5368710;   // ceil(2^27 / 25)

    localparam logic [XW-1:0] T66 = XW'(66 * 256);
    localparam logic [XW-1:0] T60 = XW'(60 * 256);
    localparam logic [XW-1:0] T19 = XW'(19 * 256);
    localparam logic [XW-1:0] T10 = XW'(10 * 256);

    localparam logic signed [LW-1:0] CH_E [3] = '{-24'sd8730, -24'sd4949, 24'sd0};
    localparam logic signed [LW-1:0] CH_A [3] = '{24'sd0, 24'sd17720, 24'sd24676};
    localparam logic signed [LW-1:0] CH_B [3] = '{24'sd0, 24'sd41408, 24'sd78398};
    localparam logic [PW-1:0]        CH_K [3] = '{17'd84734, 17'd74049, 17'd0};
    localparam logic signed [LW-1:0] GAMMA_Q16 = 24'sd144179;

    typedef enum logic [1:0] {MODE_POW, MODE_LOG, MODE_FULL, MODE_ZERO} t_mode;
    typedef enum logic [1:0] {CLS_ZERO, CLS_FULL, CLS_FRAC} t_cls;

    function automatic logic signed [LW-1:0] mul_q16(input logic signed [LW-1:0] a,
                                                     input logic signed [LW-1:0] b);
        logic            neg;
        logic [LW-1:0]   ma;
        logic [LW-1:0]   mb;
        logic [2*LW-1:0] m;
        logic signed [LW-1:0] r;
        neg = a[LW-1] ^ b[LW-1];
        ma  = a[LW-1] ? LW'(-a) : LW'(a);
        mb  = b[LW-1] ? LW'(-b) : LW'(b);
        m   = (2*LW)'(ma) * (2*LW)'(mb);
        r   = signed'(LW'(m >> 16));
        return neg ? -r : r;
    endfunction

    function automatic logic [PW-1:0] clamp_level(input logic signed [LW-1:0] v);
        if (v[LW-1]) return '0;
        if (v > signed'(LW'(ctr_pkg::ONE_Q16))) return PW'(ctr_pkg::ONE_Q16);
        return PW'(v);
    endfunction

    logic [NST-1:0]  r_vld, n_vld, w_en;
    logic [15:0]     r_full_scale;
    logic [Q0_W-1:0] r_q0;
    logic [XW-1:0]   w_t;
    logic            w_le66, w_ge66, w_le19, w_t_zero;
    logic [15:0]     w_cmp [3];

    // stage k may load when it is empty or some later stage makes room
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            w_en[k] = !(i_stall && ((r_vld | NST'((1 << k) - 1)) == {NST{1'b1}}));
        end
        n_vld = {r_vld[NST-2:0], i_valid};
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_full_scale <= 16'(ctr_pkg::FULL_SCALE_RESET);
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) r_vld[k] <= n_vld[k];
            end
            if (i_full_scale_we) r_full_scale <= i_full_scale;
        end
    end

    // t = kelvin * 256 / 100 = kelvin * 64 / 25
    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_q0 <= Q0_W'({i_kelvin, 6'b0}) * Q0_W'(DIV_M);
    end

    always_comb begin
        w_t      = r_q0[DIV_SH +: XW];
        w_le66   = (w_t <= T66);
        w_ge66   = (w_t >= T66);
        w_le19   = (w_t <= T19);
        w_t_zero = (w_t == '0);
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        t_mode                n_mode;
        t_mode                r_mode [7:1];
        logic [XW-1:0]        n_x, r_x1;
        logic signed [LW-1:0] w_l3, w_coef, r_m4, w_l10, r_z11;
        logic [PW-1:0]        w_p7, w_p14, n_lvl, r_lvl8;
        logic [PW-1:0]        r_lg [7:5];
        logic [33:0]          w_pk;
        logic [17:0]          w_pkh;
        t_cls                 n_cls;
        t_cls                 r_cls [14:9];
        logic [32:0]          w_pf;
        logic [15:0]          n_cmp, r_cmp;

        always_comb begin
            n_mode = MODE_ZERO;
            n_x    = w_t;
            if (c == 0) begin
                if (w_le66) begin
                    n_mode = MODE_FULL;
                end else begin
                    n_mode = MODE_POW;
                    n_x    = w_t - T60;
                end
            end else if (c == 1) begin
                if (!w_le66) begin
                    n_mode = MODE_POW;
                    n_x    = w_t - T60;
                end else if (w_t_zero) begin
                    n_mode = MODE_ZERO;
                end else begin
                    n_mode = MODE_LOG;
                end
            end else begin
                if (w_ge66) begin
                    n_mode = MODE_FULL;
                end else if (w_le19) begin
                    n_mode = MODE_ZERO;
                end else begin
                    n_mode = MODE_LOG;
                    n_x    = w_t - T10;
                end
            end
        end

        assign w_coef = (r_mode[3] == MODE_POW) ? CH_E[c] : CH_A[c];

        ctr_log2 #(.TB(TABLE_BITS), .FB(8)) u_log_curve (
            .i_clk (i_clk),
            .i_en  (w_en[3:2]),
            .i_x   (r_x1),
            .o_l   (w_l3)
        );

        ctr_exp2 #(.TB(TABLE_BITS)) u_exp_curve (
            .i_clk (i_clk),
            .i_en  (w_en[7:5]),
            .i_z   (r_m4),
            .o_p   (w_p7)
        );

        always_comb begin
            w_pk  = 34'(w_p7) * 34'(CH_K[c]);
            w_pkh = w_pk[33:16];
            case (r_mode[7])
                MODE_POW:  n_lvl = (w_pkh > 18'(ctr_pkg::ONE_Q16)) ?
                                   PW'(ctr_pkg::ONE_Q16) : w_pkh[PW-1:0];
                MODE_LOG:  n_lvl = r_lg[7];
                MODE_FULL: n_lvl = PW'(ctr_pkg::ONE_Q16);
                default:   n_lvl = '0;
            endcase
        end

        always_comb begin
            if (r_lvl8 == '0) n_cls = CLS_ZERO;
            else if (r_lvl8[PW-1]) n_cls = CLS_FULL;
            else n_cls = CLS_FRAC;
        end

        ctr_log2 #(.TB(TABLE_BITS), .FB(16)) u_log_gamma (
            .i_clk (i_clk),
            .i_en  (w_en[10:9]),
            .i_x   (XW'(r_lvl8)),
            .o_l   (w_l10)
        );

        ctr_exp2 #(.TB(TABLE_BITS)) u_exp_gamma (
            .i_clk (i_clk),
            .i_en  (w_en[14:12]),
            .i_z   (r_z11),
            .o_p   (w_p14)
        );

        always_comb begin
            w_pf = 33'(w_p14) * 33'(r_full_scale);
            case (r_cls[14])
                CLS_ZERO: n_cmp = '0;
                CLS_FULL: n_cmp = r_full_scale;
                default:  n_cmp = w_pf[31:16];
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (w_en[1]) begin
                r_mode[1] <= n_mode;
                r_x1      <= n_x;
            end
            for (int k = 2; k <= 7; k++) begin
                if (w_en[k]) r_mode[k] <= r_mode[k-1];
            end
            if (w_en[4]) r_m4 <= mul_q16(w_coef, w_l3);
            if (w_en[5]) r_lg[5] <= clamp_level(r_m4 - CH_B[c]);
            if (w_en[6]) r_lg[6] <= r_lg[5];
            if (w_en[7]) r_lg[7] <= r_lg[6];
            if (w_en[8]) r_lvl8 <= n_lvl;
            if (w_en[9]) r_cls[9] <= n_cls;
            for (int k = 10; k <= 14; k++) begin
                if (w_en[k]) r_cls[k] <= r_cls[k-1];
            end
            if (w_en[11]) r_z11 <= -mul_q16(GAMMA_Q16, -w_l10);
            if (w_en[15]) r_cmp <= n_cmp;
        end

        assign w_cmp[c] = r_cmp;
    end

    assign o_red_compare   = w_cmp[0];
    assign o_green_compare = w_cmp[1];
    assign o_blue_compare  = w_cmp[2];

endmodule

/* design/ctr_log2.sv */
// Two-stage log2 unit: normalize, then table lookup with linear interpolation.
// Result is signed Q16. Depends on ctr_pkg.
module ctr_log2 #(
    parameter int TB = ctr_pkg::TABLE_BITS_DEF,
    parameter int FB = 8
) (
    input  logic                             i_clk,
    input  logic [1:0]                       i_en,
    input  logic [ctr_pkg::X_W-1:0]          i_x,
    output logic signed [ctr_pkg::L_W-1:0]   o_l
);

    localparam int XW    = ctr_pkg::X_W;
    localparam int LW    = ctr_pkg::L_W;
    localparam int PW    = ctr_pkg::P_W;
    localparam int TSIZE = (1 << TB) + 1;
    localparam int RW    = XW - 1 - TB;
    localparam int EW    = $clog2(XW);

    logic [PW-1:0] w_rom [TSIZE];

    for (genvar g = 0; g < TSIZE; g++) begin : g_rom
        assign w_rom[g] = ctr_pkg::log_entry(TB, g);
    end

    logic [EW-1:0]   n_e, r_e;
    logic [XW-1:0]   w_sh;
    logic [XW-2:0]   r_fr;
    logic [TB:0]     w_i0, w_i1;
    logic [RW-1:0]   w_rem;
    logic [PW-1:0]   w_lo, w_hi, w_d, w_frac;
    logic [PW+RW-1:0] w_prod;
    logic signed [LW-1:0] w_int, n_l;

    always_comb begin
        n_e = '0;
        for (int b = 0; b < XW; b++) begin
            if (i_x[b]) n_e = EW'(b);
        end
        w_sh = i_x << (EW'(XW - 1) - n_e);
    end

    always_comb begin
        w_i0   = {1'b0, r_fr[XW-2 -: TB]};
        w_i1   = w_i0 + (TB+1)'(1);
        w_rem  = r_fr[RW-1:0];
        w_lo   = w_rom[w_i0];
        w_hi   = w_rom[w_i1];
        w_d    = w_hi - w_lo;
        w_prod = (PW+RW)'(w_d) * (PW+RW)'(w_rem);
        w_frac = w_lo + PW'(w_prod >> RW);
        w_int  = LW'(signed'({1'b0, r_e})) - LW'(FB);
        n_l    = (w_int <<< 16) + signed'(LW'(w_frac));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_e  <= n_e;
            r_fr <= w_sh[XW-2:0];
        end
        if (i_en[1]) begin
            o_l <= n_l;
        end
    end

endmodule

/* design/ctr_exp2.sv */
// Three-stage 2^z unit for signed Q16 z, result Q16 in 0..65536.
// Table lookup with linear interpolation, then a right shift. Depends on ctr_pkg.
module ctr_exp2 #(
    parameter int TB = ctr_pkg::TABLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic [2:0]                       i_en,
    input  logic signed [ctr_pkg::L_W-1:0]   i_z,
    output logic [ctr_pkg::P_W-1:0]          o_p
);

    localparam int LW     = ctr_pkg::L_W;
    localparam int PW     = ctr_pkg::P_W;
    localparam int TSIZE  = (1 << TB) + 1;
    localparam int RW     = 16 - TB;
    localparam int KW     = LW - 16 + 1;
    localparam int K_ZERO = 18;             // shift of 14+k clears a 32-bit value

    logic [31:0] w_rom [TSIZE];

    for (genvar g = 0; g < TSIZE; g++) begin : g_rom
        assign w_rom[g] = ctr_pkg::exp_entry(TB, g);
    end

    logic [LW-1:0]    w_u;
    logic [KW-1:0]    n_k, r_k1, r_k2;
    logic             r_one1, r_one2;
    logic [15:0]      r_f;
    logic [TB:0]      w_i0, w_i1;
    logic [RW-1:0]    w_rem;
    logic [31:0]      w_lo, w_hi, w_d, n_v, r_v;
    logic [31+RW:0]   w_prod;
    logic [PW-1:0]    n_p;

    always_comb begin
        w_u = LW'(-i_z);
        n_k = KW'(w_u[LW-1:16]) + KW'(w_u[15:0] != 16'd0);
    end

    always_comb begin
        w_i0   = {1'b0, r_f[15 -: TB]};
        w_i1   = w_i0 + (TB+1)'(1);
        w_rem  = r_f[RW-1:0];
        w_lo   = w_rom[w_i0];
        w_hi   = w_rom[w_i1];
        w_d    = w_hi - w_lo;
        w_prod = (32+RW)'(w_d) * (32+RW)'(w_rem);
        n_v    = w_lo + 32'(w_prod >> RW);
    end

    always_comb begin
        if (r_one2) begin
            n_p = PW'(ctr_pkg::ONE_Q16);
        end else if (r_k2 >= KW'(K_ZERO)) begin
            n_p = '0;
        end else begin
            n_p = PW'(r_v >> (5'd14 + r_k2[4:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_one1 <= !i_z[LW-1];
            r_k1   <= n_k;
            r_f    <= i_z[15:0];
        end
        if (i_en[1]) begin
            r_one2 <= r_one1;
            r_k2   <= r_k1;
            r_v    <= n_v;
        end
        if (i_en[2]) begin
            o_p <= n_p;
        end
    end

endmodule

/* sim/ctr_checker.sv */
// Checker for the color temperature to RGB compare block: watches the input
// and output sides, predicts compare values in fixed point and counts mismatches.
// Depends on ctr_pkg for the table size, the Q16 one and the reset constant.
module ctr_checker #(
    parameter int TABLE_BITS = ctr_pkg::TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_full_scale_we,
    input  logic [15:0] i_full_scale,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [15:0] i_kelvin,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_red,
    input  logic [15:0] i_green,
    input  logic [15:0] i_blue,
    output int          o_errors,
    output int          o_pending
);

    localparam int TS = (1 << TABLE_BITS) + 1;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb;

    longint unsigned log_tab[TS];
    longint unsigned exp_tab[TS];
    logic [15:0] scale;
    t_rgb rgb_q[$];

    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned r, b, w;
        r = 0;
        b = 64'd1 << 62;
        w = v;
        while (b > w) b = b >> 2;
        while (b != 0) begin
            if (w >= r + b) begin
                w = w - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    initial begin
        longint unsigned rt[TABLE_BITS+1];
        longint unsigned y, acc;
        longint unsigned fr;
        rt[0] = 64'd1 << 31;
        for (int j = 1; j <= TABLE_BITS; j++) rt[j] = sqrt_floor(rt[j-1] << 30);
        for (int i = 0; i < (1 << TABLE_BITS); i++) begin
            y = (64'd1 << 30) + (64'(i) << (30 - TABLE_BITS));
            fr = 0;
            for (int n = 0; n < 20; n++) begin
                y = (y * y) >> 30;
                fr = fr << 1;
                if (y >= (64'd1 << 31)) begin
                    fr = fr | 1;
                    y = y >> 1;
                end
            end
            log_tab[i] = (fr + 8) >> 4;
            acc = 64'd1 << 30;
            for (int j = 1; j <= TABLE_BITS; j++)
                if (((i >> (TABLE_BITS - j)) & 1) != 0) acc = (acc * rt[j]) >> 30;
            exp_tab[i] = acc;
        end
        log_tab[1 << TABLE_BITS] = ctr_pkg::ONE_Q16;
        exp_tab[1 << TABLE_BITS] = 64'd1 << 31;
    end

    function automatic longint lerp(input longint unsigned lo, input longint unsigned hi,
                                    input longint unsigned rem, input int sh);
        if (hi >= lo) return longint'(lo + (((hi - lo) * rem) >> sh));
        return longint'(lo - (((lo - hi) * rem) >> sh));
    endfunction

    function automatic longint log2_fix(input logic [31:0] x, input int fb);
        int e;
        logic [31:0] f, idx, rem;
        e = 31;
        while (e > 0 && x[e] == 1'b0) e--;
        f = (x << (31 - e)) & 32'h7FFF_FFFF;
        idx = f >> (31 - TABLE_BITS);
        rem = f & ((32'd1 << (31 - TABLE_BITS)) - 1);
        return longint'(e - fb) * ctr_pkg::ONE_Q16 +
               lerp(log_tab[idx], log_tab[idx+1], rem, 31 - TABLE_BITS);
    endfunction

    function automatic longint mul_fix(input longint a, input longint b);
        longint unsigned ma, mb;
        longint m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = longint'((ma * mb) >> 16);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint unsigned exp2_fix(input longint z);
        longint unsigned u, k, f, idx, rem, v;
        if (z >= 0) return ctr_pkg::ONE_Q16;
        u = -z;
        k = (u + 64'hFFFF) >> 16;
        f = k * 65536 - u;
        idx = f >> (16 - TABLE_BITS);
        rem = f & ((64'd1 << (16 - TABLE_BITS)) - 1);
        v = lerp(exp_tab[idx], exp_tab[idx+1], rem, 16 - TABLE_BITS);
        if (14 + k >= 63) return 0;
        return v >> (14 + k);
    endfunction

    function automatic longint clamp_lvl(input longint v);
        if (v < 0) return 0;
        if (v > ctr_pkg::ONE_Q16) return ctr_pkg::ONE_Q16;
        return v;
    endfunction

    function automatic longint power_lvl(input logic [31:0] x, input longint k,
                                         input longint e);
        longint p;
        p = exp2_fix(mul_fix(e, log2_fix(x, 8)));
        return clamp_lvl((p * k) >>> 16);
    endfunction

    function automatic logic [15:0] gamma_cmp(input longint lvl, input logic [15:0] fs);
        longint unsigned p;
        if (lvl == 0) return 16'd0;
        if (lvl >= ctr_pkg::ONE_Q16) return fs;
        p = exp2_fix(-mul_fix(144179, -log2_fix(32'(lvl), 16)));
        return 16'((p * fs) >> 16);
    endfunction

    function automatic t_rgb predict_rgb(input logic [15:0] k, input logic [15:0] fs);
        logic [31:0] t;
        longint r, g, b;
        t_rgb res;
        t = (32'(k) * 256) / 100;
        if (t <= 66 * 256) r = ctr_pkg::ONE_Q16;
        else r = power_lvl(t - 60 * 256, 84734, -8730);
        if (t > 66 * 256) g = power_lvl(t - 60 * 256, 74049, -4949);
        else if (t == 0) g = 0;
        else g = clamp_lvl(mul_fix(17720, log2_fix(t, 8)) - 41408);
        if (t >= 66 * 256) b = ctr_pkg::ONE_Q16;
        else if (t <= 19 * 256) b = 0;
        else b = clamp_lvl(mul_fix(24676, log2_fix(t - 10 * 256, 8)) - 78398);
        res.red = gamma_cmp(r, fs);
        res.green = gamma_cmp(g, fs);
        res.blue = gamma_cmp(b, fs);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rgb want;
        if (!i_rst_n) begin
            scale <= 16'(ctr_pkg::FULL_SCALE_RESET);
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_full_scale_we) scale <= i_full_scale;
            if (i_valid && !i_stall_in) rgb_q.push_back(predict_rgb(i_kelvin, scale));
            if (i_out_valid && !i_out_stall) begin
                if (rgb_q.size() == 0) begin
                    $display("%0t: unexpected transfer r=%0d g=%0d b=%0d",
                             $time, i_red, i_green, i_blue);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rgb_q.pop_front();
                    if (want != {i_red, i_green, i_blue}) begin
                        $display("%0t: expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                                 $time, want.red, want.green, want.blue,
                                 i_red, i_green, i_blue);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= rgb_q.size();
        end
    end
endmodule

/* sim/tb_top.sv */
// Testbench top for the color temperature to RGB compare block: stimulus,
// idling and verdict. Depends on the block and ctr_checker.
module tb_top;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        fs_we = 0;
    logic [15:0] fs_val = 0;
    logic        in_valid = 0;
    logic [15:0] kelvin = 0;
    logic        out_stall = 0;
    logic        in_stall, out_valid;
    logic [15:0] red, green, blue;
    int          errors, pending;
    int          snd_idle = 0, rcv_idle = 0;
    bit          hold_rcv = 0;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    color_temperature_to_rgb_pwm_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_full_scale_we(fs_we), .i_full_scale(fs_val),
        .i_valid(in_valid), .o_stall(in_stall), .i_kelvin(kelvin),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_red_compare(red), .o_green_compare(green), .o_blue_compare(blue)
    );

    ctr_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_full_scale_we(fs_we), .i_full_scale(fs_val),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_kelvin(kelvin),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_red(red), .i_green(green), .i_blue(blue),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk)
        out_stall <= hold_rcv || ($urandom_range(99) < rcv_idle);

    // valid stays high between back-to-back transfers
    task automatic send_kelvin(input logic [15:0] k);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        kelvin <= k;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [15:0] v);
        drain();
        fs_we <= 1;
        fs_val <= v;
        @(posedge i_clk);
        fs_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_kelvin;
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(12000));
            2: return 16'($urandom_range(1800, 7000));
            default: return 16'($urandom_range(6500, 6700));
        endcase
    endfunction

    initial begin
        logic [15:0] dir[] = '{0, 1, 99, 100, 1900, 1901, 1950, 2000, 6599, 6600,
                               6601, 6700, 10000, 40000, 65534, 65535, 16'h5555,
                               16'hAAAA};
        logic [15:0] scales[] = '{16'hFFFF, 0, 1, 16'h8000, 12345};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir[i]) send_kelvin(dir[i]);
        foreach (scales[s]) begin
            write_scale(scales[s]);
            foreach (dir[i]) if (i < 6) send_kelvin(dir[i + 10]);
        end
        write_scale(50000);
        snd_idle = 7;
        rcv_idle = 85;
        repeat (170) send_kelvin(rand_kelvin());
        hold_rcv = 1;
        fork
            repeat (60) send_kelvin(rand_kelvin());
            begin
                repeat (200) @(posedge i_clk);
                hold_rcv = 0;
            end
        join
        drain();
        write_scale(16'($urandom_range(65535)));
        snd_idle = 85;
        rcv_idle = 7;
        repeat (120) send_kelvin(rand_kelvin());
        write_scale(16'($urandom_range(65535)));
        snd_idle = 0;
        rcv_idle = 0;
        repeat (150) send_kelvin(rand_kelvin());
        drain();
        if (errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
